>>> design/pasa_pkg.sv
// Package for the padded array source address generator.
// Holds register indexes, pad mode codes, widths and pipeline depth constants.
// Used by padded_array_source_address; depends on nothing else.
package pasa_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_PAD_MODE     = 3'd0;
    localparam logic [2:0] REG_SOURCE_ROWS  = 3'd1;
    localparam logic [2:0] REG_SOURCE_COLS  = 3'd2;
    localparam logic [2:0] REG_SOURCE_PAGES = 3'd3;
    localparam logic [2:0] REG_ROW_OFFSET   = 3'd4;
    localparam logic [2:0] REG_COL_OFFSET   = 3'd5;
    localparam logic [2:0] REG_PAGE_OFFSET  = 3'd6;

    // Pad modes.
    localparam logic [1:0] MODE_CONSTANT  = 2'd0;
    localparam logic [1:0] MODE_REPLICATE = 2'd1;
    localparam logic [1:0] MODE_SYMMETRIC = 2'd2;
    localparam logic [1:0] MODE_CIRCULAR  = 2'd3;

    // Dimension limits.
    localparam int MAX_DIM   = 4096;
    localparam int MAX_PAGES = 256;

    // Lanes: one per axis.
    localparam int LANES     = 3;
    localparam int LANE_ROW  = 0;
    localparam int LANE_COL  = 1;
    localparam int LANE_PAGE = 2;

    // Modulo unit: one quotient bit per step over a 14-bit magnitude.
    localparam int DIV_STEPS       = 14;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

    typedef logic [12:0] dim_t;   // saturated dimension, up to 4096
    typedef logic [13:0] div_t;   // divisor, up to 2 * 4096
    typedef logic [13:0] mag_t;   // magnitude of an offset position
    typedef logic [11:0] pos_t;   // source position on one axis
    typedef logic [14:0] spos_t;  // signed position after the offset

endpackage

>>> design/padded_array_source_address.sv
// Throughput: one word per cycle while out_stall is low; the pipeline runs
// in 11 register stages with a 14-step restoring modulo unit spread over 7
// of them, two steps per stage.
// Reset: rst_n clears all valid bits and restores the register defaults
// (constant mode, 1 x 1 x 1 source, zero offsets); no clearing pass is needed.
// Source address generator for array border padding, column-major layout.
// Depends on pasa_pkg.
module padded_array_source_address (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [12:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [13:0]          out_row,
    input  logic [13:0]          out_col,
    input  logic [9:0]           out_page,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [31:0]          source_index,
    output logic                 use_pad,
    output logic                 empty_source
);
    import pasa_pkg::*;

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic [12:0] rows_reg;
    logic [12:0] cols_reg;
    logic [8:0]  pages_reg;
    logic [12:0] row_off_reg;
    logic [12:0] col_off_reg;
    logic [8:0]  page_off_reg;

    // Values derived from the configuration; divisors and page size are registered.
    dim_t        dim_cfg [LANES];
    div_t        div_reg [LANES];
    logic [24:0] hw_reg;
    logic        empty_cfg;

    // Prep and modulo stages (index 0 is the prep stage).
    logic        vd_reg      [DIV_STAGES+1];
    mag_t        rem_reg     [DIV_STAGES+1][LANES];
    mag_t        rem_next    [DIV_STAGES+1][LANES];
    logic        neg_reg     [DIV_STAGES+1][LANES];
    pos_t        direct_reg  [DIV_STAGES+1][LANES];
    logic        fold_reg    [DIV_STAGES+1];
    logic        pad_reg     [DIV_STAGES+1];
    logic        empty_reg   [DIV_STAGES+1];
    logic        en_d        [DIV_STAGES+1];

    // Fix stage, multiply stage and output stage.
    logic        vf_reg;
    pos_t        fpos_reg    [LANES];
    pos_t        fpos_next   [LANES];
    logic        fpad_reg;
    logic        fempty_reg;
    logic        vm_reg;
    logic [32:0] prod_p_reg;
    logic [24:0] prod_c_reg;
    pos_t        mrow_reg;
    logic        mpad_reg;
    logic        mempty_reg;
    logic        out_valid_reg;
    logic [31:0] index_reg;
    logic        pad_out_reg;
    logic        empty_out_reg;
    logic        en_f;
    logic        en_m;
    logic        en_out;

    // Prep stage inputs.
    spos_t       ipos        [LANES];
    mag_t        imag        [LANES];
    logic        ineg        [LANES];
    logic        iin         [LANES];
    pos_t        idirect     [LANES];
    logic        iall_in;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_CONSTANT;
            rows_reg     <= 13'd1;
            cols_reg     <= 13'd1;
            pages_reg    <= 9'd1;
            row_off_reg  <= 13'd0;
            col_off_reg  <= 13'd0;
            page_off_reg <= 9'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PAD_MODE:     mode_reg     <= cfg_data[1:0];
                REG_SOURCE_ROWS:  rows_reg     <= cfg_data;
                REG_SOURCE_COLS:  cols_reg     <= cfg_data;
                REG_SOURCE_PAGES: pages_reg    <= cfg_data[8:0];
                REG_ROW_OFFSET:   row_off_reg  <= cfg_data;
                REG_COL_OFFSET:   col_off_reg  <= cfg_data;
                REG_PAGE_OFFSET:  page_off_reg <= cfg_data[8:0];
                default:          ;
            endcase
        end
    end

    // Saturated dimensions and the empty-source flag follow the registers directly.
    always_comb
    begin
        dim_cfg[LANE_ROW]  = (rows_reg > 13'(MAX_DIM)) ? 13'(MAX_DIM) : rows_reg;
        dim_cfg[LANE_COL]  = (cols_reg > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cols_reg;
        dim_cfg[LANE_PAGE] = (pages_reg > 9'(MAX_PAGES)) ? 13'(MAX_PAGES)
                                                         : {4'd0, pages_reg};
        empty_cfg = (dim_cfg[LANE_ROW] == 13'd0) || (dim_cfg[LANE_COL] == 13'd0)
                    || (dim_cfg[LANE_PAGE] == 13'd0);
    end

    // Modulo divisors (first needed one stage after entry) and the page size H * W.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                div_reg[l] <= 14'd1;
            end
            hw_reg <= 25'd1;
        end
        else
        begin
            for (int l = 0; l < LANES; l++)
            begin
                div_reg[l] <= (mode_reg == MODE_SYMMETRIC) ? {dim_cfg[l], 1'b0}
                                                           : {1'b0, dim_cfg[l]};
            end
            hw_reg <= 25'(dim_cfg[LANE_ROW] * dim_cfg[LANE_COL]);
        end
    end

    // Stage enables: a stage moves when it is empty or its successor moves.
    always_comb
    begin
        en_out = !out_valid_reg || !out_stall;
        en_m   = !vm_reg || en_out;
        en_f   = !vf_reg || en_m;
        en_d[DIV_STAGES] = !vd_reg[DIV_STAGES] || en_f;
        for (int s = DIV_STAGES - 1; s >= 0; s--)
        begin
            en_d[s] = !vd_reg[s] || en_d[s+1];
        end
    end
    assign in_stall = !en_d[0];

    // Offset removal, range check, clamp value and magnitude for the modulo unit.
    always_comb
    begin
        ipos[LANE_ROW] = $signed({1'b0, out_row}) - $signed({2'b0, row_off_reg});
        ipos[LANE_COL] = $signed({1'b0, out_col}) - $signed({2'b0, col_off_reg});
        if (dim_cfg[LANE_PAGE] == 13'd1)
        begin
            ipos[LANE_PAGE] = '0;
        end
        else
        begin
            ipos[LANE_PAGE] = $signed({5'b0, out_page}) - $signed({6'b0, page_off_reg});
        end
        iall_in = 1'b1;
        for (int l = 0; l < LANES; l++)
        begin
            ineg[l] = ipos[l][14];
            imag[l] = ineg[l] ? 14'(-ipos[l]) : ipos[l][13:0];
            iin[l]  = !ineg[l] && (ipos[l][13:0] < {1'b0, dim_cfg[l]});
            if (iin[l])
            begin
                idirect[l] = ipos[l][11:0];
            end
            else if (ineg[l])
            begin
                idirect[l] = '0;
            end
            else
            begin
                idirect[l] = 12'(dim_cfg[l] - 13'd1);
            end
            iall_in = iall_in && iin[l];
        end
    end

    // One restoring modulo step per quotient bit, two bits per stage.
    always_comb
    begin
        logic [27:0] shifted;
        logic [27:0] wide;
        for (int l = 0; l < LANES; l++)
        begin
            rem_next[0][l] = imag[l];
        end
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_next[s][l] = rem_reg[s-1][l];
                for (int t = 0; t < STEPS_PER_STAGE; t++)
                begin
                    shifted = {14'd0, div_reg[l]} << (DIV_STEPS - 1
                              - (s - 1) * STEPS_PER_STAGE - t);
                    wide    = {14'd0, rem_next[s][l]};
                    if (wide >= shifted)
                    begin
                        rem_next[s][l] = rem_next[s][l] - shifted[13:0];
                    end
                end
            end
        end
    end

    // Prep and modulo pipeline registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                vd_reg[s] <= 1'b0;
            end
        end
        else
        begin
            if (en_d[0])
            begin
                vd_reg[0] <= in_valid;
            end
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                if (en_d[s])
                begin
                    vd_reg[s] <= vd_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d[0])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l]    <= rem_next[0][l];
                neg_reg[0][l]    <= ineg[l];
                direct_reg[0][l] <= idirect[l];
            end
            fold_reg[0]  <= (mode_reg == MODE_SYMMETRIC) || (mode_reg == MODE_CIRCULAR);
            pad_reg[0]   <= (mode_reg == MODE_CONSTANT) && !iall_in;
            empty_reg[0] <= empty_cfg;
        end
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            if (en_d[s])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l]    <= rem_next[s][l];
                    neg_reg[s][l]    <= neg_reg[s-1][l];
                    direct_reg[s][l] <= direct_reg[s-1][l];
                end
                fold_reg[s]  <= fold_reg[s-1];
                pad_reg[s]   <= pad_reg[s-1];
                empty_reg[s] <= empty_reg[s-1];
            end
        end
    end

    // Turn the remainder into a floor modulo, then reflect in symmetric mode.
    always_comb
    begin
        mag_t j;
        for (int l = 0; l < LANES; l++)
        begin
            j = rem_reg[DIV_STAGES][l];
            if (neg_reg[DIV_STAGES][l] && (j != '0))
            begin
                j = div_reg[l] - j;
            end
            if ((mode_reg == MODE_SYMMETRIC) && (j >= {1'b0, dim_cfg[l]}))
            begin
                j = div_reg[l] - 14'd1 - j;
            end
            fpos_next[l] = fold_reg[DIV_STAGES] ? j[11:0] : direct_reg[DIV_STAGES][l];
        end
    end

    // Fix, multiply and output stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_f)
            begin
                vf_reg <= vd_reg[DIV_STAGES];
            end
            if (en_m)
            begin
                vm_reg <= vf_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= vm_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            fpos_reg   <= fpos_next;
            fpad_reg   <= pad_reg[DIV_STAGES];
            fempty_reg <= empty_reg[DIV_STAGES];
        end
        if (en_m)
        begin
            prod_p_reg <= fpos_reg[LANE_PAGE][7:0] * hw_reg;
            prod_c_reg <= fpos_reg[LANE_COL] * dim_cfg[LANE_ROW];
            mrow_reg   <= fpos_reg[LANE_ROW];
            mpad_reg   <= fpad_reg;
            mempty_reg <= fempty_reg;
        end
        if (en_out)
        begin
            if (mpad_reg || mempty_reg)
            begin
                index_reg <= '0;
            end
            else
            begin
                index_reg <= 32'(prod_p_reg + {8'd0, prod_c_reg} + {21'd0, mrow_reg});
            end
            pad_out_reg   <= mpad_reg;
            empty_out_reg <= mempty_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign source_index = index_reg;
    assign use_pad      = pad_out_reg;
    assign empty_source = empty_out_reg;

    // A padded word carries a zero index.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && use_pad |-> source_index == 32'd0)
        else $error("padded word with nonzero index");

    // An empty source gives a zero index.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_source |-> source_index == 32'd0)
        else $error("empty source with nonzero index");

    // The input is never stalled while the first stage is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !vd_reg[0] |-> !in_stall)
        else $error("input stalled with empty first stage");

    // A word in the fix stage moves on when the multiply stage is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        vf_reg && !vm_reg |=> vm_reg)
        else $error("word lost between fix and multiply stages");

endmodule

>>> tb/padded_array_source_address_tb.sv
`timescale 1ns / 100ps
// Testbench for padded_array_source_address: drives output coordinates under
// several register settings and checks every result word against a predictor.
// Depends on pasa_pkg and the padded_array_source_address RTL.
module padded_array_source_address_tb;
    import pasa_pkg::*;

    typedef struct packed {
        logic [31:0] index;
        logic        pad;
        logic        empty;
    } addr_word_t;

    typedef struct {
        logic [13:0] row;
        logic [13:0] col;
        logic [9:0]  page;
        logic        known;
        addr_word_t  word;
    } coord_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [13:0] out_row;
    logic [13:0] out_col;
    logic [9:0]  out_page;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] source_index;
    logic        use_pad;
    logic        empty_source;

    // Shadow copy of the configuration registers.
    logic [1:0]  mode_q;
    logic [12:0] rows_q;
    logic [12:0] cols_q;
    logic [8:0]  pages_q;
    logic [12:0] roff_q;
    logic [12:0] coff_q;
    logic [8:0]  poff_q;

    addr_word_t  pending_addrs[$];
    int          failures;
    int          words_sent;
    int          words_checked;
    int          modes_seen;
    int          hold_off_len;
    int          idle_pct;

    padded_array_source_address dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_row(out_row), .out_col(out_col), .out_page(out_page),
        .out_valid(out_valid), .out_stall(out_stall),
        .source_index(source_index), .use_pad(use_pad), .empty_source(empty_source)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("padded_array_source_address test failed");
        $finish;
    end

    // Map one position on an axis into the source range for the folding modes.
    function automatic longint fold_axis(longint i, longint n, logic [1:0] mode);
        longint j;
        if (n <= 0) return 0;
        if (i >= 0 && i < n) return i;
        if (mode == MODE_SYMMETRIC)
        begin
            j = i % (2 * n);
            if (j < 0) j += 2 * n;
            if (j >= n) j = 2 * n - 1 - j;
            return j;
        end
        if (mode == MODE_CIRCULAR)
        begin
            j = i % n;
            if (j < 0) j += n;
            return j;
        end
        return (i < 0) ? 0 : n - 1;
    endfunction

    // Source address predicted for one output coordinate.
    function automatic addr_word_t source_addr(logic [13:0] row, logic [13:0] col,
                                               logic [9:0] page);
        addr_word_t w;
        longint h, wd, pg, r, c, p, rs, cs, ps;
        logic [63:0] idx;
        h  = (rows_q > MAX_DIM) ? MAX_DIM : rows_q;
        wd = (cols_q > MAX_DIM) ? MAX_DIM : cols_q;
        pg = (pages_q > MAX_PAGES) ? MAX_PAGES : pages_q;
        r  = longint'(row) - longint'(roff_q);
        c  = longint'(col) - longint'(coff_q);
        p  = (pg == 1) ? 0 : longint'(page) - longint'(poff_q);
        idx = 0;
        w.pad = 1'b0;
        w.empty = (h == 0 || wd == 0 || pg == 0);
        if (mode_q == MODE_CONSTANT)
        begin
            if (r < 0 || r >= h || c < 0 || c >= wd || p < 0 || p >= pg)
                w.pad = 1'b1;
            else
                idx = p * h * wd + c * h + r;
        end
        else if (!w.empty)
        begin
            rs = fold_axis(r, h, mode_q);
            cs = fold_axis(c, wd, mode_q);
            ps = (pg == 1) ? 0 : fold_axis(p, pg, mode_q);
            idx = ps * h * wd + cs * h + rs;
        end
        if (w.empty) idx = 0;
        w.index = idx[31:0];
        return w;
    endfunction

    // Register write, only issued while the pipeline is empty.
    task automatic write_reg(logic [2:0] index, logic [12:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (index)
            REG_PAD_MODE:     mode_q  = value[1:0];
            REG_SOURCE_ROWS:  rows_q  = value;
            REG_SOURCE_COLS:  cols_q  = value;
            REG_SOURCE_PAGES: pages_q = value[8:0];
            REG_ROW_OFFSET:   roff_q  = value;
            REG_COL_OFFSET:   coff_q  = value;
            REG_PAGE_OFFSET:  poff_q  = value[8:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [1:0] mode, logic [12:0] rows, logic [12:0] cols,
                                logic [8:0] pages, logic [12:0] roff, logic [12:0] coff,
                                logic [8:0] poff);
        write_reg(REG_PAD_MODE, 13'(mode));
        write_reg(REG_SOURCE_ROWS, rows);
        write_reg(REG_SOURCE_COLS, cols);
        write_reg(REG_SOURCE_PAGES, 13'(pages));
        write_reg(REG_ROW_OFFSET, roff);
        write_reg(REG_COL_OFFSET, coff);
        write_reg(REG_PAGE_OFFSET, 13'(poff));
        modes_seen++;
    endtask

    // Drop the input, wait for every expected word, then let the pipeline settle.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_addrs.size() != 0) @(posedge clk);
        repeat (14) @(posedge clk);
    endtask

    // Offer one coordinate word and hold it until accepted; valid stays high
    // afterwards so that the next call can follow back to back.
    task automatic send_coord(logic [13:0] row, logic [13:0] col, logic [9:0] page,
                              bit known, addr_word_t want);
        addr_word_t pred;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        out_row  <= row;
        out_col  <= col;
        out_page <= page;
        pred = source_addr(row, col, page);
        if (known && pred !== want)
        begin
            $error("directed row disagrees with predictor: %h vs %h", want, pred);
            failures++;
        end
        if (known)
            pred = want;
        do @(posedge clk); while (in_stall);
        pending_addrs.insert(pending_addrs.size(), pred);
        words_sent++;
        @(negedge clk);
    endtask

    // Coordinates near the edges of the source and of its padding.
    function automatic logic [13:0] pick_axis(logic [12:0] n, logic [12:0] off, int hi);
        int v;
        case ($urandom_range(3))
            0: v = $urandom_range(hi);
            1: v = off + $urandom_range(2) - 1;
            2: v = off + n + $urandom_range(2) - 1;
            default: v = $urandom_range(off + 2 * n + 8);
        endcase
        if (v < 0) v = 0;
        if (v > hi) v = hi;
        return v[13:0];
    endfunction

    // Receiver: random stalls and one long hold-off.
    initial
    begin
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_len > 0)
            begin
                out_stall <= 1'b1;
                hold_off_len--;
            end
            else
                out_stall <= (idle_pct != 0 && $urandom_range(99) < idle_pct);
        end
    end

    // Word checker.
    always @(posedge clk)
    begin
        addr_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_addrs.size() == 0)
            begin
                $error("unexpected word: source_index %h", source_index);
                failures++;
            end
            else
            begin
                want = pending_addrs.pop_front();
                words_checked++;
                if (source_index !== want.index)
                begin
                    $error("source_index: expected %h, got %h", want.index, source_index);
                    failures++;
                end
                if (use_pad !== want.pad)
                begin
                    $error("use_pad: expected %b, got %b", want.pad, use_pad);
                    failures++;
                end
                if (empty_source !== want.empty)
                begin
                    $error("empty_source: expected %b, got %b", want.empty, empty_source);
                    failures++;
                end
            end
        end
    end

    // Directed coordinates under the reset geometry.
    coord_row_t directed[] = '{
        '{14'd0, 14'd0, 10'd0, 1'b1, '{32'd0, 1'b0, 1'b0}},
        '{14'd1, 14'd0, 10'd0, 1'b1, '{32'd0, 1'b1, 1'b0}},
        '{14'd0, 14'd1, 10'd0, 1'b1, '{32'd0, 1'b1, 1'b0}},
        '{14'd0, 14'd0, 10'd1023, 1'b1, '{32'd0, 1'b0, 1'b0}},
        '{14'd16383, 14'd16383, 10'd1023, 1'b1, '{32'd0, 1'b1, 1'b0}}
    };

    // Main stimulus sequence.
    initial
    begin
        int n;
        int m;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_PAD_MODE;
        cfg_data = '0;
        in_valid = 1'b0;
        out_row = '0;
        out_col = '0;
        out_page = '0;
        failures = 0;
        words_sent = 0;
        words_checked = 0;
        modes_seen = 0;
        hold_off_len = 0;
        idle_pct = 37;
        mode_q = MODE_CONSTANT;
        rows_q = 13'd1;
        cols_q = 13'd1;
        pages_q = 9'd1;
        roff_q = '0;
        coff_q = '0;
        poff_q = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_coord(directed[i].row, directed[i].col, directed[i].page,
                       directed[i].known, directed[i].word);
        drain_pipeline();

        // Each mode on a small 3-D source with offsets, around every edge.
        for (m = 0; m < 4; m++)
        begin
            set_geometry(m[1:0], 13'd4, 13'd5, 9'd3, 13'd2, 13'd3, 9'd1);
            send_coord(14'd0, 14'd0, 10'd0, 1'b0, '0);
            send_coord(14'd5, 14'd7, 10'd3, 1'b0, '0);
            send_coord(14'd16383, 14'd16383, 10'd1023, 1'b0, '0);
            send_coord(14'd2, 14'd3, 10'd1, 1'b0, '0);
            drain_pipeline();
        end
        // Empty source in constant and circular mode.
        set_geometry(MODE_CONSTANT, 13'd0, 13'd7, 9'd2, 13'd0, 13'd0, 9'd0);
        send_coord(14'd0, 14'd0, 10'd0, 1'b1, '{32'd0, 1'b1, 1'b1});
        drain_pipeline();
        set_geometry(MODE_CIRCULAR, 13'd7, 13'd7, 9'd0, 13'd0, 13'd0, 9'd0);
        send_coord(14'd3, 14'd3, 10'd0, 1'b1, '{32'd0, 1'b0, 1'b1});
        drain_pipeline();

        // Random phases; the first has no idling, one has a long receiver hold-off.
        for (n = 0; n < 16; n++)
        begin
            logic [12:0] rows, cols, roff, coff;
            logic [8:0] pages, poff;
            if (n == 0 || n == 15)
            begin
                rows = 13'(n == 0 ? 8191 : 4096);
                cols = 13'(n == 0 ? 8191 : 4096);
                pages = 9'(n == 0 ? 511 : 256);
                roff = 13'(n == 0 ? 8191 : 0);
                coff = 13'(n == 0 ? 0 : 8191);
                poff = 9'(n == 0 ? 511 : 0);
            end
            else
            begin
                rows = 13'($urandom_range(1, 12));
                cols = 13'($urandom_range(1, 12));
                pages = ($urandom_range(3) == 0) ? 9'd1 : 9'($urandom_range(1, 5));
                roff = 13'($urandom_range(0, 8));
                coff = 13'($urandom_range(0, 8));
                poff = 9'($urandom_range(0, 4));
                if ($urandom_range(9) == 0) rows = 13'($urandom_range(1, 8191));
            end
            set_geometry(2'(n % 4), rows, cols, pages, roff, coff, poff);
            idle_pct = (n == 0) ? 0 : 37;
            if (n == 3) hold_off_len = 60;
            for (m = 0; m < 100; m++)
                send_coord(pick_axis(rows, roff, 16383), pick_axis(cols, coff, 16383),
                           10'(pick_axis(13'(pages), 13'(poff), 1023)), 1'b0, '0);
            // Sender pauses until every expected word is back.
            drain_pipeline();
        end

        $display("Covered %0d words (%0d checked) over %0d register settings in all four pad modes.",
                 words_sent, words_checked, modes_seen);
        if (failures == 0 && pending_addrs.size() == 0)
            $display("padded_array_source_address test passed");
        else
            $display("padded_array_source_address test failed");
        $finish;
    end

endmodule
